>>> rtl/mmm_pkg.sv
package mmm_pkg;
  localparam int MaxLimbs = 6;
  localparam int LimbBits = 64;
  localparam int HalfBits = LimbBits / 2;
  localparam int ScalarLimbs = 4;
  localparam int BaseLimbs = 6;

  localparam logic FIELD_SCALAR = 1'b0;
  localparam logic FIELD_BASE = 1'b1;

  typedef logic [LimbBits-1:0] limb_t;

  // Modulus limb for the chosen field; limbs past the field width read as zero.
  function automatic limb_t mod_limb(input logic field, input logic [2:0] idx);
    limb_t r;
    r = '0;
    if (field == FIELD_BASE) begin
      case (idx)
        3'd0: r = 64'hb9feffffffffaaab;
        3'd1: r = 64'h1eabfffeb153ffff;
        3'd2: r = 64'h6730d2a0f6b0f624;
        3'd3: r = 64'h64774b84f38512bf;
        3'd4: r = 64'h4b1ba7b6434bacd7;
        3'd5: r = 64'h1a0111ea397fe69a;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        3'd0: r = 64'hffffffff00000001;
        3'd1: r = 64'h53bda402fffe5bfe;
        3'd2: r = 64'h3339d80809a1d805;
        3'd3: r = 64'h73eda753299d7d48;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic limb_t ninv(input logic field);
    return (field == FIELD_BASE) ? 64'h89f3fffcfffcfffd : 64'hfffffffeffffffff;
  endfunction

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_MUL_AB,
    OP_MUL_M,
    OP_MUL_N,
    OP_CMP,
    OP_SUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] j;
    logic [1:0] ph;
    logic       first;
    logic       last;
    logic       field;
  } dp_cmd_t;
endpackage

>>> rtl/mmm_if.sv
interface mmm_in_if import mmm_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t a_limb;
  limb_t b_limb;
  logic  func;
  modport source(output valid, a_limb, b_limb, func, input ready);
  modport sink(input valid, a_limb, b_limb, func, output ready);
endinterface

interface mmm_out_if import mmm_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t result_limb;
  logic  last_limb;
  modport source(output valid, result_limb, last_limb, input ready);
  modport sink(input valid, result_limb, last_limb, output ready);
endinterface

>>> rtl/mmm_dp.sv
module mmm_dp import mmm_pkg::*; (
  input  logic       clk,
  input  dp_cmd_t    cmd,
  input  logic       wr_en,
  input  logic [2:0] wr_idx,
  input  limb_t      wr_a,
  input  limb_t      wr_b,
  input  logic [2:0] i_idx,
  output limb_t      out_limb
);
  limb_t a_store [MaxLimbs];
  limb_t b_store [MaxLimbs];
  limb_t t [MaxLimbs+2];
  limb_t carry;
  limb_t m;
  logic  borrow;
  logic  ge_hi;
  logic  decided;
  limb_t x, y, addc, tj_add;
  logic [HalfBits-1:0] xs, ys;
  logic [LimbBits-1:0] pp;
  logic [2*LimbBits-1:0] pp_sh, acc, acc_base, acc_new;
  logic [2:0] n, n_m1, n_p1;
  logic [2:0] jm1;
  limb_t nl, tj;
  logic [LimbBits:0] dif;
  logic [LimbBits:0] top;
  logic [LimbBits:0] top_n;

  assign n = (cmd.field == FIELD_BASE) ? 3'(BaseLimbs) : 3'(ScalarLimbs);
  assign n_m1 = n - 3'd1;
  assign n_p1 = n + 3'd1;
  assign jm1 = cmd.j - 3'd1;
  assign nl = mod_limb(cmd.field, cmd.j);
  assign tj = t[cmd.j];

  // One 64x64 multiply-accumulate is built from four 32x32 partial products:
  // ph picks the partial product and its weight.
  always_comb begin
    x = a_store[cmd.j];
    y = b_store[i_idx];
    tj_add = tj;
    addc = carry;
    if (cmd.op == OP_MUL_M) begin
      x = t[0];
      y = ninv(cmd.field);
      tj_add = '0;
      addc = '0;
    end else if (cmd.op == OP_MUL_N) begin
      x = m;
      y = nl;
    end
    if (cmd.first) addc = '0;
    xs = cmd.ph[1] ? x[LimbBits-1:HalfBits] : x[HalfBits-1:0];
    ys = cmd.ph[0] ? y[LimbBits-1:HalfBits] : y[HalfBits-1:0];
    pp = xs * ys;
    case (cmd.ph)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_base = (cmd.ph == 2'd0) ? ({64'd0, tj_add} + {64'd0, addc}) : acc;
    acc_new = acc_base + pp_sh;
    dif = {1'b0, tj} - {1'b0, nl} - {64'd0, borrow};
    top = {1'b0, t[n]} + {1'b0, carry};
    top_n = {1'b0, t[n]} + {1'b0, acc_new[2*LimbBits-1:LimbBits]};
  end

  assign out_limb = tj;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_store[wr_idx] <= wr_a;
      b_store[wr_idx] <= wr_b;
    end
    case (cmd.op)
      OP_CLEAR: begin
        for (int k = 0; k < MaxLimbs+2; k++) t[k] <= '0;
        carry <= '0;
      end
      OP_MUL_AB: begin
        acc <= acc_new;
        if (cmd.ph == 2'd3) begin
          t[cmd.j] <= acc_new[LimbBits-1:0];
          carry <= acc_new[2*LimbBits-1:LimbBits];
        end
      end
      OP_MUL_M: begin
        acc <= acc_new;
        if (cmd.ph == 2'd3) begin
          // fold the a*b row carry into t[n], t[n+1]
          t[n] <= top[LimbBits-1:0];
          t[n_p1] <= {63'd0, top[LimbBits]};
          m <= acc_new[LimbBits-1:0];
        end
      end
      OP_MUL_N: begin
        acc <= acc_new;
        if (cmd.ph == 2'd3) begin
          if (cmd.j != 3'd0) t[jm1] <= acc_new[LimbBits-1:0];
          carry <= acc_new[2*LimbBits-1:LimbBits];
          if (cmd.last) begin
            t[n_m1] <= top_n[LimbBits-1:0];
            t[n] <= t[n_p1] + {63'd0, top_n[LimbBits]};
            t[n_p1] <= '0;
          end
        end
      end
      OP_CMP: begin
        // scan from top limb down; j runs n-1..0
        if (cmd.first) begin
          decided <= (t[n] != '0);
          ge_hi <= 1'b1;
          if (t[n] == '0) begin
            if (tj > nl) decided <= 1'b1;
            else if (tj < nl) begin decided <= 1'b1; ge_hi <= 1'b0; end
          end
        end else if (!decided) begin
          if (tj > nl) decided <= 1'b1;
          else if (tj < nl) begin decided <= 1'b1; ge_hi <= 1'b0; end
        end
        borrow <= 1'b0;
      end
      OP_SUB: begin
        // subtract in place, least significant limb first
        if (ge_hi) begin
          t[cmd.j] <= dif[LimbBits-1:0];
          borrow <= dif[LimbBits];
        end
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/mmm_ctrl.sv
module mmm_ctrl import mmm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mmm_in_if.sink     in_ch,
  mmm_out_if.source  out_ch,
  input  limb_t      dp_limb,
  output dp_cmd_t    cmd,
  output logic       wr_en,
  output logic [2:0] wr_idx,
  output logic [2:0] i_idx
);
  typedef enum logic [2:0] {S_LOAD, S_AB, S_M, S_N, S_CMP, S_SUB, S_OUT} state_t;
  state_t state;
  logic [2:0] cnt, j, i;
  logic [1:0] ph;
  logic field;
  logic [2:0] n;
  logic acc;
  logic [2:0] sub_j;

  assign n = (field == FIELD_BASE) ? 3'(BaseLimbs) : 3'(ScalarLimbs);
  assign in_ch.ready = (state == S_LOAD);
  assign acc = in_ch.valid && in_ch.ready;
  assign wr_en = acc;
  assign wr_idx = cnt;
  assign i_idx = i;
  assign out_ch.result_limb = dp_limb;

  always_comb begin
    cmd.op = OP_IDLE;
    cmd.j = j;
    cmd.ph = ph;
    cmd.first = (j == 3'd0);
    cmd.last = (j == n - 3'd1);
    cmd.field = field;
    case (state)
      S_LOAD: begin
        cmd.op = (acc && cnt == 3'd0) ? OP_CLEAR : OP_IDLE;
      end
      S_AB: cmd.op = OP_MUL_AB;
      S_M: begin cmd.op = OP_MUL_M; cmd.j = 3'd0; end
      S_N: begin cmd.op = OP_MUL_N; cmd.first = (j == 3'd0); end
      S_CMP: begin
        cmd.op = OP_CMP;
        cmd.j = n - 3'd1 - j;
        cmd.first = (j == 3'd0);
        cmd.last = (j == n - 3'd1);
      end
      S_SUB: begin cmd.op = OP_SUB; cmd.j = sub_j; end
      S_OUT: begin cmd.op = OP_IDLE; cmd.j = sub_j; end
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0;
      j <= '0;
      i <= '0;
      ph <= '0;
      field <= FIELD_SCALAR;
      sub_j <= '0;
      out_ch.valid <= 1'b0;
      out_ch.last_limb <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (acc) begin
          if (cnt == 3'd0) field <= in_ch.func;
          if ((cnt == 3'd0 && !in_ch.func && ScalarLimbs == 1) ||
              (cnt != 3'd0 && cnt == n - 3'd1)) begin
            cnt <= '0;
            state <= S_AB;
            j <= '0;
            i <= '0;
            ph <= '0;
          end else cnt <= cnt + 3'd1;
        end
        // each multiply step runs through ph 0..3
        S_AB: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (j == n - 3'd1) state <= S_M; else j <= j + 3'd1;
          end
        end
        S_M: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin j <= '0; state <= S_N; end
        end
        S_N: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (j == n - 3'd1) begin
              j <= '0;
              if (i == n - 3'd1) state <= S_CMP;
              else begin i <= i + 3'd1; state <= S_AB; end
            end else j <= j + 3'd1;
          end
        end
        S_CMP: if (j == n - 3'd1) begin
          j <= '0;
          sub_j <= '0;
          state <= S_SUB;
        end else j <= j + 3'd1;
        S_SUB: if (sub_j == n - 3'd1) begin
          state <= S_OUT;
          sub_j <= '0;
          out_ch.valid <= 1'b1;
          out_ch.last_limb <= (n == 3'd1);
        end else sub_j <= sub_j + 3'd1;
        S_OUT: if (out_ch.ready) begin
          if (out_ch.last_limb) begin
            out_ch.valid <= 1'b0;
            state <= S_LOAD;
          end else begin
            sub_j <= sub_j + 3'd1;
            out_ch.last_limb <= (sub_j + 3'd2 == n);
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

>>> rtl/montgomery_modular_multiplier_unit.sv
// Montgomery product a*b*R^-1 mod N (CIOS, 64-bit limbs) for the BLS12-381
// scalar field (func=0, 4 limbs) or base field (func=1, 6 limbs). Feed limb
// pairs least significant first, one beat each; func is taken from the first
// beat. After the last pair the unit runs n rows of (n a*b steps, one m step,
// n modulus steps), each step built from four 32x32 partial products on one
// shared 32x32 multiplier, then n compare and n subtract steps. The result
// follows as n beats with last_limb on the final one. Input is not taken
// during compute/output.
module montgomery_modular_multiplier_unit import mmm_pkg::*; (
  input logic       clk,
  input logic       rst,
  mmm_in_if.sink    in_ch,
  mmm_out_if.source out_ch
);
  dp_cmd_t    cmd;
  logic       wr_en;
  logic [2:0] wr_idx, i_idx;
  limb_t      dp_limb;

  mmm_ctrl u_ctrl (
    .clk, .rst, .in_ch, .out_ch, .dp_limb, .cmd, .wr_en, .wr_idx, .i_idx
  );

  mmm_dp u_dp (
    .clk, .cmd, .wr_en, .wr_idx, .wr_a(in_ch.a_limb), .wr_b(in_ch.b_limb),
    .i_idx, .out_limb(dp_limb)
  );
endmodule

>>> rtl/mmm_checker.sv
module mmm_checker import mmm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last_limb
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_limb |=> !out_valid) else $error("extra beat");
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind montgomery_modular_multiplier_unit mmm_checker u_chk (
  .clk, .rst, .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .last_limb(out_ch.last_limb)
);
